/* rtl/sarg_pkg.sv */
// Shared widths, register indexes and defaults of the strided argmax block.
`timescale 1ns / 1ps
package sarg_pkg;

  // Fixed field widths
  localparam int ELEM_W     = 32;
  localparam int IDX_W      = 16;
  localparam int OUTER_W    = 21;
  localparam int AXIS_W     = 17;
  localparam int INNER_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd2;

  // Count limits
  localparam int OUTER_MAX = 1048576;
  localparam int AXIS_MAX  = 65536;
  localparam int OUTER_POS_W = 20;
  localparam int AXIS_POS_W  = 16;

  // Parameter defaults
  localparam int MAX_INNER_DEF   = 4096;
  localparam int VALUE_WIDTH_DEF = 32;

endpackage

/* rtl/sarg_in_if.sv */
// Element input channel: valid/ready with one tensor element.
`timescale 1ns / 1ps
interface sarg_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sarg_pkg::ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

/* rtl/sarg_out_if.sv */
// Result channel: valid/ready with the argmax index and the last-result flag.
`timescale 1ns / 1ps
interface sarg_out_if;
  logic                       valid;
  logic                       ready;
  logic [sarg_pkg::IDX_W-1:0] best_position;
  logic                       final_result;

  modport source (output valid, output best_position, output final_result, input ready);
  modport sink   (input valid, input best_position, input final_result, output ready);
endinterface

/* rtl/sarg_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
`timescale 1ns / 1ps
interface sarg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sarg_pkg::CFG_IDX_W-1:0]  index;
  logic [sarg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sarg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read (read-first).
`timescale 1ns / 1ps
module sarg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = sarg_pkg::MAX_INNER_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/strided_argmax_reduction.sv */
// Top level of the strided argmax reduction.
//
// Usage: elements of an outer x axis x inner tensor arrive on in_ch one per
// transaction in row-major order. For each inner position the running maximum
// and its axis index live in one RAM entry. When the last axis step of a
// position is taken, one transaction leaves on out_ch with the axis index of
// the first maximum; final_result marks the last result of the tensor.
// cfg_ch writes outer_count (0), axis_length (1) and inner_count (2); a zero
// count acts as one, too large a count saturates, and a write to one of these
// registers restarts the tensor at position zero; other indexes are ignored.
// cfg_ch is always ready; write only while idle.
// Throughput: one element per cycle sustained while out_ch takes results. An element
// passes the RAM read, then the compare/update stage, and its result is registered in
// the output register. A back-to-back hit on the same entry is served by forwarding
// the write-back data into the compare stage.
// Reset clears the positions and sets all counts to one; RAM contents are not
// cleared, since each entry is written on axis step zero before it is read.
// When out_ch stalls, the result sits in the output register; elements that
// end no axis keep passing the compare stage, and in_ch.ready drops once the
// next result-producing element waits there.
`timescale 1ns / 1ps
module strided_argmax_reduction #(
  parameter int MAX_INNER   = sarg_pkg::MAX_INNER_DEF,
  parameter int VALUE_WIDTH = sarg_pkg::VALUE_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sarg_in_if.sink    in_ch,
  sarg_out_if.source out_ch,
  sarg_cfg_if.sink   cfg_ch
);

  localparam int IW  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int VW  = VALUE_WIDTH;
  localparam int XW  = sarg_pkg::IDX_W;
  localparam int MW  = VW + XW;
  localparam int OPW = sarg_pkg::OUTER_POS_W;
  localparam int APW = sarg_pkg::AXIS_POS_W;

  // Shape registers hold effective count minus one
  logic [OPW-1:0] outer_last_r, outer_last_nxt;
  logic [APW-1:0] axis_last_r, axis_last_nxt;
  logic [IW-1:0]  inner_last_r, inner_last_nxt;

  // Tensor positions
  logic [OPW-1:0] outer_pos_r, outer_pos_nxt;
  logic [APW-1:0] axis_pos_r, axis_pos_nxt;
  logic [IW-1:0]  inner_pos_r, inner_pos_nxt;

  // Compare stage
  logic                 s1_v_r;
  logic signed [VW-1:0] s1_val_r;
  logic [APW-1:0]       s1_axis_r;
  logic [IW-1:0]        s1_slot_r;
  logic                 s1_first_r;
  logic                 s1_prod_r;
  logic                 s1_final_r;
  logic                 fwd_v_r;
  logic [MW-1:0]        fwd_data_r;

  // Output register
  logic          out_v_r;
  logic [XW-1:0] out_pos_r;
  logic          out_final_r;

  logic                 cfg_wr;
  logic                 cfg_restart;
  logic                 in_acc;
  logic                 s1_fire;
  logic                 out_free;
  logic signed [VW-1:0] in_val;
  logic                 wr_en;
  logic [MW-1:0]        wr_data;
  logic [MW-1:0]        rd_data;
  logic [MW-1:0]        cur_data;
  logic signed [VW-1:0] cur_val;
  logic [XW-1:0]        cur_idx;
  logic signed [VW-1:0] new_val;
  logic [XW-1:0]        new_idx;
  logic                 pos_last_in;
  logic                 outer_end;
  logic                 axis_end;
  logic                 inner_end;

  logic [OPW:0]   outer_eff;
  logic [APW:0]   axis_eff;
  logic [16:0]    inner_eff;
  logic [16:0]    inner_raw;

  // Handshakes
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign out_free     = !out_v_r || out_ch.ready;
  assign s1_fire      = s1_v_r && (!s1_prod_r || out_free);
  assign in_ch.ready  = !s1_v_r || s1_fire;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Only a write to a defined register restarts the tensor
  assign cfg_restart = cfg_wr && ((cfg_ch.index == sarg_pkg::REG_OUTER_COUNT) ||
                                  (cfg_ch.index == sarg_pkg::REG_AXIS_LENGTH) ||
                                  (cfg_ch.index == sarg_pkg::REG_INNER_COUNT));

  // Element value: low VALUE_WIDTH bits taken as signed, or zero-extended when wider
  generate
    if (VW <= sarg_pkg::ELEM_W) begin : g_narrow
      assign in_val = in_ch.element_value[VW-1:0];
    end else begin : g_wide
      assign in_val = {{(VW - sarg_pkg::ELEM_W){1'b0}}, in_ch.element_value};
    end
  endgenerate

  // Count clamping for a configuration write
  assign inner_raw = {{(17 - sarg_pkg::INNER_W){1'b0}}, cfg_ch.data[sarg_pkg::INNER_W-1:0]};
  always_comb begin
    if (cfg_ch.data == '0) begin
      outer_eff = (OPW + 1)'(1);
    end else if (cfg_ch.data > sarg_pkg::CFG_DATA_W'(sarg_pkg::OUTER_MAX)) begin
      outer_eff = (OPW + 1)'(sarg_pkg::OUTER_MAX);
    end else begin
      outer_eff = cfg_ch.data[OPW:0];
    end
    if (cfg_ch.data[sarg_pkg::AXIS_W-1:0] == '0) begin
      axis_eff = (APW + 1)'(1);
    end else if (cfg_ch.data[sarg_pkg::AXIS_W-1:0] > (APW + 1)'(sarg_pkg::AXIS_MAX)) begin
      axis_eff = (APW + 1)'(sarg_pkg::AXIS_MAX);
    end else begin
      axis_eff = cfg_ch.data[APW:0];
    end
    if (inner_raw == '0) begin
      inner_eff = 17'd1;
    end else if (inner_raw > 17'(MAX_INNER)) begin
      inner_eff = 17'(MAX_INNER);
    end else begin
      inner_eff = inner_raw;
    end
  end

  // Shape register writes
  always_comb begin
    outer_last_nxt = outer_last_r;
    axis_last_nxt  = axis_last_r;
    inner_last_nxt = inner_last_r;
    if (cfg_wr) begin
      unique case (cfg_ch.index)
        sarg_pkg::REG_OUTER_COUNT: begin
          outer_last_nxt = OPW'(outer_eff - (OPW + 1)'(1));
        end
        sarg_pkg::REG_AXIS_LENGTH: begin
          axis_last_nxt = APW'(axis_eff - (APW + 1)'(1));
        end
        sarg_pkg::REG_INNER_COUNT: begin
          inner_last_nxt = IW'(inner_eff - 17'd1);
        end
        default: begin
        end
      endcase
    end
  end

  // Position counters: inner fastest, then axis, then outer
  assign inner_end = (inner_pos_r == inner_last_r);
  assign axis_end  = (axis_pos_r == axis_last_r);
  assign outer_end = (outer_pos_r == outer_last_r);
  assign pos_last_in = axis_end;

  always_comb begin
    outer_pos_nxt = outer_pos_r;
    axis_pos_nxt  = axis_pos_r;
    inner_pos_nxt = inner_pos_r;
    if (cfg_restart) begin
      outer_pos_nxt = '0;
      axis_pos_nxt  = '0;
      inner_pos_nxt = '0;
    end else if (in_acc) begin
      if (!inner_end) begin
        inner_pos_nxt = inner_pos_r + IW'(1);
      end else begin
        inner_pos_nxt = '0;
        if (!axis_end) begin
          axis_pos_nxt = axis_pos_r + APW'(1);
        end else begin
          axis_pos_nxt = '0;
          outer_pos_nxt = outer_end ? '0 : outer_pos_r + OPW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_last_r <= '0;
      axis_last_r  <= '0;
      inner_last_r <= '0;
      outer_pos_r  <= '0;
      axis_pos_r   <= '0;
      inner_pos_r  <= '0;
    end else begin
      outer_last_r <= outer_last_nxt;
      axis_last_r  <= axis_last_nxt;
      inner_last_r <= inner_last_nxt;
      outer_pos_r  <= outer_pos_nxt;
      axis_pos_r   <= axis_pos_nxt;
      inner_pos_r  <= inner_pos_nxt;
    end
  end

  // Running best value and index per inner position
  sarg_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_INNER),
    .AW    (IW)
  ) u_best_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_slot_r),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (inner_pos_r),
    .rd_data (rd_data)
  );

  // Compare stage: forwarded data wins when the write-back hit the entry being read
  assign cur_data = fwd_v_r ? fwd_data_r : rd_data;
  assign cur_val  = cur_data[MW-1:XW];
  assign cur_idx  = cur_data[XW-1:0];

  always_comb begin
    if (s1_first_r) begin
      new_val = s1_val_r;
      new_idx = '0;
    end else if (s1_val_r > cur_val) begin
      new_val = s1_val_r;
      new_idx = s1_axis_r;
    end else begin
      new_val = cur_val;
      new_idx = cur_idx;
    end
  end

  assign wr_en   = s1_fire;
  assign wr_data = {new_val, new_idx};

  // Stage registers; payload loads on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_val_r   <= in_val;
      s1_axis_r  <= axis_pos_r;
      s1_slot_r  <= inner_pos_r;
      s1_first_r <= (axis_pos_r == '0);
      s1_prod_r  <= pos_last_in;
      s1_final_r <= outer_end && inner_end;
      fwd_v_r    <= wr_en && (s1_slot_r == inner_pos_r);
      fwd_data_r <= wr_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire && s1_prod_r) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_prod_r) begin
      out_pos_r   <= new_idx;
      out_final_r <= s1_final_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.best_position = out_pos_r;
  assign out_ch.final_result  = out_final_r;

endmodule

/* bench/strided_argmax_reduction_tb.sv */
// Self-checking testbench for strided_argmax_reduction: directed, random and saturated shapes.
`timescale 1ns / 1ps
module strided_argmax_reduction_tb;
  import sarg_pkg::*;

  localparam int STORE_DEPTH    = MAX_INNER_DEF;
  localparam int RANDOM_ITEMS   = 850;
  localparam int SAT_ITEMS      = 64;
  localparam int SETTLE_CYCLES  = 6;
  localparam int LIMIT_CYCLES   = 1500000;
  localparam int MAX_REPORTS    = 50;
  // Index 3 selects no register; a write there must leave the tensor alone
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [IDX_W-1:0] position;
    logic             last_flag;
  } argmax_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sarg_in_if  in_ch ();
  sarg_out_if out_ch ();
  sarg_cfg_if cfg_ch ();

  strided_argmax_reduction u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: counts, scan positions and per-column running max
  logic [OUTER_W-1:0]       outer_count_q;
  logic [AXIS_W-1:0]        axis_length_q;
  logic [INNER_W-1:0]       inner_count_q;
  int unsigned              outer_pos, axis_pos, inner_pos;
  logic signed [ELEM_W-1:0] run_max_value [STORE_DEPTH];
  logic [IDX_W-1:0]         run_max_index [STORE_DEPTH];
  argmax_result_t           pending_argmax [$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  sender_idle = 1'b1;
  bit  sink_idle   = 1'b1;

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned outer_eff();
    return clamp_count(outer_count_q, OUTER_MAX);
  endfunction

  function automatic int unsigned axis_eff();
    return clamp_count(axis_length_q, AXIS_MAX);
  endfunction

  function automatic int unsigned inner_eff();
    return clamp_count(inner_count_q, STORE_DEPTH);
  endfunction

  function automatic void rewind_scan();
    outer_pos = 0;
    axis_pos  = 0;
    inner_pos = 0;
  endfunction

  // Mirror of a register write; only real registers restart the tensor
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_OUTER_COUNT: begin
        outer_count_q = value[OUTER_W-1:0];
        rewind_scan();
      end
      REG_AXIS_LENGTH: begin
        axis_length_q = value[AXIS_W-1:0];
        rewind_scan();
      end
      REG_INNER_COUNT: begin
        inner_count_q = value[INNER_W-1:0];
        rewind_scan();
      end
      default: ;
    endcase
  endfunction

  // Running argmax update for one accepted element; queues the index at axis end
  function automatic void track_element(input logic signed [ELEM_W-1:0] v);
    int unsigned    n_outer, n_axis, n_inner, slot;
    argmax_result_t res;
    n_outer = outer_eff();
    n_axis  = axis_eff();
    n_inner = inner_eff();
    if (outer_pos >= n_outer || axis_pos >= n_axis || inner_pos >= n_inner)
      rewind_scan();
    slot = inner_pos;
    // first maximum wins: replace only when strictly greater
    if (axis_pos == 0) begin
      run_max_value[slot] = v;
      run_max_index[slot] = '0;
    end else if (v > run_max_value[slot]) begin
      run_max_value[slot] = v;
      run_max_index[slot] = axis_pos[IDX_W-1:0];
    end
    if (axis_pos == n_axis - 1) begin
      res.position  = run_max_index[slot];
      res.last_flag = (outer_pos == n_outer - 1) && (inner_pos == n_inner - 1);
      pending_argmax = {pending_argmax, res};
    end
    // advance inner fastest, then axis, then outer; wrap after the tensor
    inner_pos++;
    if (inner_pos >= n_inner) begin
      inner_pos = 0;
      axis_pos++;
      if (axis_pos >= n_axis) begin
        axis_pos = 0;
        outer_pos++;
        if (outer_pos >= n_outer) outer_pos = 0;
      end
    end
  endfunction

  function automatic logic signed [ELEM_W-1:0] draw_value();
    case ($urandom_range(0, 5))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2, 3:    return ELEM_W'($signed($urandom_range(0, 4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_result();
    argmax_result_t want;
    if (pending_argmax.size() == 0) begin
      flag_mismatch($sformatf("unexpected result position=%0d final=%0b",
                              out_ch.best_position, out_ch.final_result));
    end else begin
      want = pending_argmax.pop_front();
      if (out_ch.best_position !== want.position)
        flag_mismatch($sformatf("best_position got %0d want %0d",
                                out_ch.best_position, want.position));
      if (out_ch.final_result !== want.last_flag)
        flag_mismatch($sformatf("final_result got %0b want %0b",
                                out_ch.final_result, want.last_flag));
    end
  endtask

  // Result sink: checks each transaction, then may stall before the next one
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        stall = sink_idle ? $urandom_range(0, 11) : 0;
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("strided_argmax_reduction: mismatch");
      $finish;
    end
  end

  // One element transaction; valid stays high on return for back-to-back sends
  task automatic send_element(input logic signed [ELEM_W-1:0] v);
    int gap;
    gap = sender_idle ? $urandom_range(0, 11) : 0;
    cfg_ch.valid <= 1'b0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_element(v);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_register(idx, value);
  endtask

  task automatic set_shape(input int unsigned n_outer, input int unsigned n_axis,
                           input int unsigned n_inner);
    write_register(REG_OUTER_COUNT, CFG_DATA_W'(n_outer));
    write_register(REG_AXIS_LENGTH, CFG_DATA_W'(n_axis));
    write_register(REG_INNER_COUNT, CFG_DATA_W'(n_inner));
  endtask

  // Stop sending, wait for every expected result, then let the pipeline empty
  task automatic drain_results();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (pending_argmax.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Counts of one after reset: every element is its own result, marked final
  task automatic test_default_shape();
    send_element(ELEM_MIN);
    send_element(ELEM_MAX);
    drain_results();
  endtask

  // Ties keep the earliest index
  task automatic test_first_max_wins();
    set_shape(1, 5, 1);
    send_element(5);
    send_element(9);
    send_element(9);
    send_element(-3);
    send_element(9);
    drain_results();
    set_shape(1, 3, 1);
    repeat (3) send_element(ELEM_MIN);
    drain_results();
  endtask

  task automatic test_zero_counts();
    set_shape(0, 0, 0);
    send_element(ELEM_MAX);
    send_element(0);
    drain_results();
  endtask

  // Interleaved columns: two outer blocks of 2 axis x 2 inner
  task automatic test_strided_layout();
    set_shape(2, 2, 2);
    send_element(10);
    send_element(-1);
    send_element(3);
    send_element(7);
    send_element(ELEM_MIN);
    send_element(ELEM_MAX);
    send_element(ELEM_MIN);
    send_element(-2);
    drain_results();
  endtask

  // A write mid-tensor starts a fresh tensor
  task automatic test_write_restarts();
    set_shape(1, 3, 1);
    send_element(100);
    send_element(200);
    drain_results();
    write_register(REG_AXIS_LENGTH, CFG_DATA_W'(3));
    send_element(-5);
    send_element(-6);
    send_element(ELEM_MAX);
    drain_results();
  endtask

  // Unused index: the partial tensor continues
  task automatic test_unused_register();
    set_shape(1, 3, 1);
    send_element(1);
    drain_results();
    write_register(REG_UNUSED, '1);
    send_element(4);
    send_element(2);
    drain_results();
  endtask

  task automatic test_random_shapes();
    int sent, n, tensor_size, i;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // full-width register noise: big shapes, few or no results
        write_register(REG_INNER_COUNT,
                       CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
        write_register(REG_OUTER_COUNT,
                       CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
        write_register(REG_AXIS_LENGTH,
                       CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
        n = $urandom_range(1, 40);
      end else begin
        set_shape($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 5));
        tensor_size = outer_eff() * axis_eff() * inner_eff();
        n = tensor_size * $urandom_range(1, 2);
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      end
      if ($urandom_range(0, 7) == 0)
        write_register(REG_UNUSED, CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
      for (i = 0; i < n; i++) begin
        // occasional pause mid-tensor until the sink has caught up
        if (i == n / 2 && $urandom_range(0, 3) == 0) drain_results();
        send_element(draw_value());
      end
      sent += n;
      drain_results();
    end
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
  endtask

  // Outer count at and above its ceiling: no result may be marked final
  task automatic test_outer_saturation();
    set_shape('1, 2, 3);
    repeat (24) send_element(draw_value());
    drain_results();
    write_register(REG_OUTER_COUNT, CFG_DATA_W'(OUTER_MAX));
    repeat (12) send_element(draw_value());
    drain_results();
  endtask

  // Inner count clamped to the store depth: axis of one gives index zero, none final
  task automatic test_inner_saturation();
    set_shape(1, 1, '1);
    repeat (SAT_ITEMS) send_element(draw_value());
    drain_results();
  endtask

  // Axis clamped to its ceiling: a partial tensor gives no result
  task automatic test_axis_saturation();
    sender_idle = 1'b0;
    set_shape(1, '1, 1);
    repeat (SAT_ITEMS) send_element(draw_value());
    drain_results();
    sender_idle = 1'b1;
  endtask

  initial begin : stimulus
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.element_value <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    outer_count_q = 1;
    axis_length_q = 1;
    inner_count_q = 1;
    rewind_scan();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_default_shape();
    test_first_max_wins();
    test_zero_counts();
    test_strided_layout();
    test_write_restarts();
    test_unused_register();
    test_random_shapes();
    test_outer_saturation();
    test_inner_saturation();
    test_axis_saturation();

    if (error_count == 0) begin
      $display("strided_argmax_reduction: match");
    end else begin
      $display("strided_argmax_reduction: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sarg_pkg.sv
rtl/sarg_in_if.sv
rtl/sarg_out_if.sv
rtl/sarg_cfg_if.sv
rtl/sarg_ram.sv
rtl/strided_argmax_reduction.sv
bench/strided_argmax_reduction_tb.sv
